// File: rtl/cdg_pkg.sv
package cdg_pkg;

    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int PIX_W          = 8;
    localparam int GRAD_W         = 9;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int OPQ_DEPTH      = 2;
    localparam int OUTQ_DEPTH     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cdg_reg_idx_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cdg_cmd_t;

    typedef struct packed {
        logic emit;
        logic gx_en;
        logic gy_en;
        logic row_end;
        logic frame_end;
    } cdg_op_flags_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic                     row_end;
        logic                     frame_end;
    } cdg_result_t;

endpackage

// File: rtl/cdg_ram.sv
module cdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/cdg_fifo.sv
module cdg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/cdg_front.sv
module cdg_front #(
    parameter int MAX_WIDTH  = cdg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cdg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             command,
    input  logic [cdg_pkg::PIX_W-1:0]        pixel,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cdg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cdg_pkg::CFG_W-1:0]        cfg_data,
    output logic                             op_push,
    input  logic                             op_full,
    output cdg_pkg::cdg_op_flags_t           op_flags,
    output logic [cdg_pkg::PIX_W-1:0]        op_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]     op_col
);

    import cdg_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
    localparam int DIM_A  = (CFG_W > WMAX_W) ? CFG_W : WMAX_W;
    localparam int DIM_W  = (DIM_A > ROW_W) ? DIM_A : ROW_W;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [DIM_W-1:0] w_raw, h_raw, w_eff, h_eff;
    logic [DIM_W-1:0] col_ext, row_ext;
    logic             accept;
    logic             drain_row;
    logic             last_col;
    logic             take;

    assign cfg_ready = 1'b1;
    assign full      = op_full;
    assign accept    = push && !op_full;

    // clamp sizes to 1..max
    always_comb
    begin
        w_raw = DIM_W'(width_reg);
        h_raw = DIM_W'(height_reg);
        if (w_raw == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (w_raw > DIM_W'(MAX_WIDTH))
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end
        if (h_raw == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (h_raw > DIM_W'(MAX_HEIGHT))
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_raw;
        end
    end

    assign col_ext   = DIM_W'(col_reg);
    assign row_ext   = DIM_W'(row_reg);
    assign drain_row = (row_ext >= h_eff);
    assign last_col  = ((col_ext + DIM_W'(1)) >= w_eff);
    // drop drains outside the drain row
    assign take      = accept && !((command == CMD_DRAIN) && !drain_row);

    always_comb
    begin
        op_push            = take;
        op_col             = col_reg;
        op_pixel           = drain_row ? '0 : pixel;
        op_flags.emit      = (row_reg != '0);
        op_flags.gx_en     = (col_reg != '0) && !last_col;
        op_flags.gy_en     = (row_reg > ROW_W'(1)) && !drain_row;
        op_flags.row_end   = last_col;
        op_flags.frame_end = last_col && drain_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = drain_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cdg_reg_idx_t'(cfg_index))
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(RESET_WIDTH);
            height_reg <= CFG_W'(RESET_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: rtl/cdg_back.sv
module cdg_back #(
    parameter int MAX_WIDTH  = cdg_pkg::DEF_MAX_WIDTH,
    parameter int OUT_DEPTH  = cdg_pkg::OUTQ_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    output logic                             q_pop,
    input  cdg_pkg::cdg_op_flags_t           q_flags,
    input  logic [cdg_pkg::PIX_W-1:0]        q_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]     q_col,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
    output logic                             res_push,
    output cdg_pkg::cdg_result_t             res
);

    import cdg_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic                issue;
    logic [CNT_W:0]      pending;

    logic                s1_valid_reg;
    cdg_op_flags_t       s1_flags_reg;
    logic [PIX_W-1:0]    s1_pix_reg;
    logic [COL_W-1:0]    s1_col_reg;

    logic                lw_valid_reg;
    logic [COL_W-1:0]    lw_col_reg;
    logic [PIX_W-1:0]    lw_pix_reg;
    logic [PIX_W-1:0]    lw_old_reg;
    logic [PIX_W-1:0]    lh_reg, lh_next;

    logic [PIX_W-1:0]    ctr_a_rd, ctr_b_rd, abv_rd;
    logic [PIX_W-1:0]    old_px, right_px, above_px;
    logic [COL_W-1:0]    s1_col_p1;
    logic [GRAD_W-1:0]   gx_diff, gy_diff;

    // reserve output space for the op in flight and the one being issued
    assign pending = {1'b0, out_count} + (CNT_W + 1)'(s1_valid_reg);
    assign issue   = !q_empty && (pending < (CNT_W + 1)'(OUT_DEPTH));
    assign q_pop   = issue;

    cdg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_center_a (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (issue),
        .raddr (q_col),
        .rdata (ctr_a_rd)
    );

    cdg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_center_b (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (issue),
        .raddr (q_col + COL_W'(1)),
        .rdata (ctr_b_rd)
    );

    cdg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (old_px),
        .re    (issue),
        .raddr (q_col),
        .rdata (abv_rd)
    );

    // forward the write that landed on the same edge as this read
    assign s1_col_p1 = s1_col_reg + COL_W'(1);
    always_comb
    begin
        old_px   = ctr_a_rd;
        right_px = ctr_b_rd;
        above_px = abv_rd;
        if (lw_valid_reg && (lw_col_reg == s1_col_reg))
        begin
            old_px   = lw_pix_reg;
            above_px = lw_old_reg;
        end
        if (lw_valid_reg && (lw_col_reg == s1_col_p1))
        begin
            right_px = lw_pix_reg;
        end
    end

    assign gx_diff = {1'b0, right_px} - {1'b0, lh_reg};
    assign gy_diff = {1'b0, s1_pix_reg} - {1'b0, above_px};

    always_comb
    begin
        res_push      = s1_valid_reg && s1_flags_reg.emit;
        res.grad_x    = s1_flags_reg.gx_en ? $signed(gx_diff) : '0;
        res.grad_y    = s1_flags_reg.gy_en ? $signed(gy_diff) : '0;
        res.row_end   = s1_flags_reg.row_end;
        res.frame_end = s1_flags_reg.frame_end;
    end

    always_comb
    begin
        lh_next = lh_reg;
        if (s1_valid_reg)
        begin
            lh_next = s1_flags_reg.row_end ? '0 : old_px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            lh_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= issue;
            lw_valid_reg <= s1_valid_reg;
            lh_reg       <= lh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_flags_reg <= q_flags;
            s1_pix_reg   <= q_pixel;
            s1_col_reg   <= q_col;
        end
        if (s1_valid_reg)
        begin
            lw_col_reg <= s1_col_reg;
            lw_pix_reg <= s1_pix_reg;
            lw_old_reg <= old_px;
        end
    end

endmodule

// File: rtl/central_difference_gradient_top.sv
// Channel   Direction  Handshake               Payload
// input     in         push / full             command, pixel
// result    out        pop / empty             grad_x, grad_y, row_end, frame_end
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per clock while the result side keeps up; the row stores do one read-modify-write per
// cycle with same-edge write forwarding, which sets that rate.
// A result passes through the op queue, the back-end stage register and the output queue; results
// trail the input by one row, flushed by a row of drain items.
// Reset clears counters and queues and sets the sizes to 640 x 480; row stores are not cleared.
// A stalled result side fills the output queue, then the op queue, then raises full.
module central_difference_gradient_top #(
    parameter int MAX_WIDTH  = cdg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cdg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                command,
    input  logic [cdg_pkg::PIX_W-1:0]           pixel,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [cdg_pkg::GRAD_W-1:0]   grad_x,
    output logic signed [cdg_pkg::GRAD_W-1:0]   grad_y,
    output logic                                row_end,
    output logic                                frame_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cdg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cdg_pkg::CFG_W-1:0]           cfg_data
);

    import cdg_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int FLAG_W = $bits(cdg_op_flags_t);
    localparam int OP_W   = FLAG_W + PIX_W + COL_W;
    localparam int RES_W  = $bits(cdg_result_t);

    logic                 op_push, op_full, op_empty, op_pop;
    cdg_op_flags_t        op_flags;
    logic [PIX_W-1:0]     op_pixel;
    logic [COL_W-1:0]     op_col;
    logic [OP_W-1:0]      op_wdata, op_rdata;
    logic [$clog2(OPQ_DEPTH+1)-1:0] op_count;

    cdg_op_flags_t        q_flags;
    logic [PIX_W-1:0]     q_pixel;
    logic [COL_W-1:0]     q_col;

    logic                 res_push, res_full;
    cdg_result_t          res, res_head;
    logic [$clog2(OUTQ_DEPTH+1)-1:0] out_count;

    cdg_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_push   (op_push),
        .op_full   (op_full),
        .op_flags  (op_flags),
        .op_pixel  (op_pixel),
        .op_col    (op_col)
    );

    assign op_wdata = {op_flags, op_pixel, op_col};

    cdg_fifo #(.WIDTH(OP_W), .DEPTH(OPQ_DEPTH)) u_op_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (op_wdata),
        .pop   (op_pop),
        .rdata (op_rdata),
        .full  (op_full),
        .empty (op_empty),
        .count (op_count)
    );

    assign q_flags = cdg_op_flags_t'(op_rdata[OP_W-1 -: FLAG_W]);
    assign q_pixel = op_rdata[COL_W +: PIX_W];
    assign q_col   = op_rdata[COL_W-1:0];

    cdg_back #(.MAX_WIDTH(MAX_WIDTH), .OUT_DEPTH(OUTQ_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (op_empty),
        .q_pop     (op_pop),
        .q_flags   (q_flags),
        .q_pixel   (q_pixel),
        .q_col     (q_col),
        .out_count (out_count),
        .res_push  (res_push),
        .res       (res)
    );

    cdg_fifo #(.WIDTH(RES_W), .DEPTH(OUTQ_DEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .pop   (pop),
        .rdata (res_head),
        .full  (res_full),
        .empty (empty),
        .count (out_count)
    );

    // credit check in the back end keeps res_full from ever blocking a push
    logic unused_status;
    assign unused_status = res_full ^ (op_count == '0);

    assign grad_x    = res_head.grad_x;
    assign grad_y    = res_head.grad_y;
    assign row_end   = res_head.row_end;
    assign frame_end = res_head.frame_end;

endmodule

// File: rtl/cdg_checker.sv
module cdg_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic signed [cdg_pkg::GRAD_W-1:0]   grad_x,
    input logic signed [cdg_pkg::GRAD_W-1:0]   grad_y,
    input logic                                row_end,
    input logic                                frame_end
);

    import cdg_pkg::*;

    // queues come up empty with room to take input
    a_reset_clear: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not clear during reset");

    // hold the waiting result until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(grad_x) && $stable(grad_y)
                              && $stable(row_end) && $stable(frame_end)))
        else $error("result changed while stalled");

    // last column of a row has no right neighbor
    a_row_end_gx: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && row_end) |-> (grad_x == '0))
        else $error("nonzero grad_x on row end");

    // frame end is the last column of the last row
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> (row_end && grad_y == '0))
        else $error("bad frame end transaction");

endmodule

bind central_difference_gradient_top cdg_checker u_cdg_checker (.*);

// File: dv/central_difference_gradient_top_tb.sv
`timescale 1ns / 100ps

module central_difference_gradient_top_tb;

    import cdg_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    localparam int RANDOM_PIXELS = 650;
    localparam int PRIME_WIDTH   = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int PRINT_LIMIT   = 50;

    // index with no register behind it; the block must ignore the write
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic                       command;
    logic [PIX_W-1:0]           pixel;
    logic                       empty;
    logic                       pop;
    logic signed [GRAD_W-1:0]   grad_x;
    logic signed [GRAD_W-1:0]   grad_y;
    logic                       row_end;
    logic                       frame_end;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    // gradient predictor state
    logic [PIX_W-1:0]   line_cur [MAX_W];
    logic [PIX_W-1:0]   line_prev [MAX_W];
    logic [PIX_W-1:0]   left_px;
    logic [9:0]         col_pos;
    logic [10:0]        row_pos;
    logic [CFG_W-1:0]   cfg_width;
    logic [CFG_W-1:0]   cfg_height;

    cdg_result_t grad_expected [$];

    int error_count;
    int pixels_taken;
    int burst_left;
    int cycle_count;
    bit hold_request;

    central_difference_gradient_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance the predictor by one transaction; returns 1 when a result is due.
    function automatic bit predict_gradient(input cdg_cmd_t cmd, input logic [PIX_W-1:0] pix,
                                            output cdg_result_t res);
        int w;
        int h;
        int c;
        int r;
        bit drain_row;
        bit last_col;
        logic [PIX_W-1:0] held;
        logic [PIX_W-1:0] p;
        w = clamp_dim(cfg_width, MAX_W);
        h = clamp_dim(cfg_height, MAX_H);
        c = col_pos;
        r = row_pos;
        drain_row = (r >= h);
        last_col = (c + 1 >= w);
        res = '0;
        predict_gradient = 1'b0;
        // drain outside the drain row: dropped, no state change
        if (cmd == CMD_DRAIN && !drain_row)
            return 1'b0;
        pixels_taken++;
        p = drain_row ? 8'd0 : pix;
        held = line_cur[c];
        if (r >= 1)
        begin
            if (c >= 1 && !last_col)
                res.grad_x = 9'(line_cur[c + 1]) - 9'(left_px);
            // result row is r-1; it needs a row above and a row below
            if (r >= 2 && r < h)
                res.grad_y = 9'(p) - 9'(line_prev[c]);
            res.row_end = last_col;
            res.frame_end = last_col && drain_row;
            predict_gradient = 1'b1;
        end
        left_px = held;
        line_prev[c] = held;
        line_cur[c] = p;
        if (last_col)
        begin
            col_pos = '0;
            left_px = '0;
            row_pos = drain_row ? 11'd0 : 11'(r + 1);
        end
        else
            col_pos = 10'(c + 1);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_item(input cdg_cmd_t cmd, input logic [PIX_W-1:0] pix);
        cdg_result_t res;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        push <= 1'b1;
        command <= cmd;
        pixel <= pix;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (predict_gradient(cmd, pix, res))
            grad_expected.push_back(res);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (grad_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH: cfg_width = value;
            REG_FRAME_HEIGHT: cfg_height = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Feed one frame until the position counters wrap; optionally resize midway.
    task automatic stream_frame(input bit cut_short);
        int fed;
        int cut_at;
        bit in_drain;
        fed = 0;
        cut_at = cut_short ? $urandom_range(0, 30) : -1;
        do
        begin
            if (fed == cut_at)
            begin
                wait_idle();
                if ($urandom_range(0, 1))
                    write_register(REG_FRAME_WIDTH, 11'($urandom_range(0, 16)));
                else
                    write_register(REG_FRAME_HEIGHT, 11'($urandom_range(0, 8)));
            end
            in_drain = (row_pos >= clamp_dim(cfg_height, MAX_H));
            if (!in_drain && $urandom_range(0, 24) == 0)
                send_item(CMD_DRAIN, random_pixel());
            send_item((in_drain && $urandom_range(0, 1)) ? CMD_DRAIN : CMD_PIXEL, random_pixel());
            fed++;
        end
        while (row_pos != 0 || col_pos != 0);
    endtask

    task automatic test_resize_mid_row();
        // still at reset size: start a wide row, then narrow it under the cursor
        send_item(CMD_DRAIN, 8'd255);
        send_item(CMD_PIXEL, 8'd0);
        send_item(CMD_PIXEL, 8'd0);
        send_item(CMD_PIXEL, 8'd255);
        send_item(CMD_PIXEL, 8'd1);
        send_item(CMD_PIXEL, 8'd2);
        wait_idle();
        write_register(REG_FRAME_WIDTH, 11'd3);
        write_register(REG_FRAME_HEIGHT, 11'd3);
        send_item(CMD_PIXEL, 8'd3);
        send_item(CMD_PIXEL, 8'd255);
        send_item(CMD_PIXEL, 8'd128);
        send_item(CMD_PIXEL, 8'd0);
        send_item(CMD_PIXEL, 8'd0);
        send_item(CMD_PIXEL, 8'd255);
        send_item(CMD_PIXEL, 8'd9);
        send_item(CMD_PIXEL, 8'd255);
        send_item(CMD_DRAIN, 8'd0);
        send_item(CMD_DRAIN, 8'd255);
    endtask

    task automatic test_height_cut_mid_frame();
        wait_idle();
        write_register(REG_UNMAPPED, 11'h7FF);
        write_register(REG_FRAME_HEIGHT, 11'd4);
        repeat (3) send_item(CMD_PIXEL, 8'd255);
        send_item(CMD_PIXEL, 8'd17);
        send_item(CMD_PIXEL, 8'd200);
        send_item(CMD_PIXEL, 8'd40);
        repeat (3) send_item(CMD_PIXEL, 8'd0);
        // row 3 becomes the drain row once the height drops to 2
        wait_idle();
        write_register(REG_FRAME_HEIGHT, 11'd2);
        send_item(CMD_PIXEL, 8'd77);
        send_item(CMD_DRAIN, 8'd0);
        send_item(CMD_DRAIN, 8'd255);
    endtask

    task automatic test_extreme_sizes();
        // zero sizes act as a one-pixel frame
        wait_idle();
        write_register(REG_FRAME_WIDTH, 11'd0);
        write_register(REG_FRAME_HEIGHT, 11'd0);
        stream_frame(1'b0);
        // fill both row stores across the widest row the later frames use
        wait_idle();
        write_register(REG_FRAME_WIDTH, 11'(PRIME_WIDTH));
        write_register(REG_FRAME_HEIGHT, 11'd1);
        stream_frame(1'b0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_register(REG_FRAME_WIDTH, 11'd16);
        write_register(REG_FRAME_HEIGHT, 11'd4);
        // receiver holds off while this frame keeps offering input
        hold_request = 1'b1;
        stream_frame(1'b0);
    endtask

    task automatic test_random_frames();
        int taken_start;
        int w;
        int h;
        taken_start = pixels_taken;
        while (pixels_taken - taken_start < RANDOM_PIXELS)
        begin
            // sometimes keep the size and run frames back to back
            if ($urandom_range(0, 3) != 0)
            begin
                wait_idle();
                w = ($urandom_range(0, 3) == 0) ? $urandom_range(11, PRIME_WIDTH)
                                                : $urandom_range(1, 10);
                h = $urandom_range(1, 8);
                if ($urandom_range(0, 9) == 0)
                    w = 0;
                if ($urandom_range(0, 9) == 0)
                    h = 0;
                if ($urandom_range(0, 1))
                begin
                    write_register(REG_FRAME_WIDTH, 11'(w));
                    write_register(REG_FRAME_HEIGHT, 11'(h));
                end
                else
                begin
                    write_register(REG_FRAME_HEIGHT, 11'(h));
                    write_register(REG_FRAME_WIDTH, 11'(w));
                end
            end
            stream_frame($urandom_range(0, 5) == 0);
        end
    endtask

    // Result side: check each transaction, then pick the next pop.
    initial
    begin : result_check
        cdg_result_t want;
        int hold_left;
        int pop_run;
        bit pop_on;
        bit hold_done;
        hold_left = 0;
        pop_run = 0;
        pop_on = 1'b0;
        hold_done = 1'b0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (grad_expected.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = grad_expected.pop_front();
                    if (grad_x !== want.grad_x)
                        report_mismatch($sformatf("grad_x %0d, expected %0d",
                                                  grad_x, want.grad_x));
                    if (grad_y !== want.grad_y)
                        report_mismatch($sformatf("grad_y %0d, expected %0d",
                                                  grad_y, want.grad_y));
                    if (row_end !== want.row_end)
                        report_mismatch($sformatf("row_end %b, expected %b",
                                                  row_end, want.row_end));
                    if (frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end %b, expected %b",
                                                  frame_end, want.frame_end));
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!hold_done && hold_request)
            begin
                // long hold-off: let the queues fill and push back on the input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
            begin
                if (pop_run == 0)
                begin
                    pop_on = ($urandom_range(0, 3) != 0);
                    if (!pop_on)
                        pop_run = $urandom_range(1, 8);
                    else if ($urandom_range(0, 7) == 0)
                        pop_run = 200;
                    else
                        pop_run = $urandom_range(1, 30);
                end
                pop_run--;
                pop <= pop_on;
            end
        end
    end

    initial
    begin
        push <= 1'b0;
        command <= CMD_PIXEL;
        pixel <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= '0;
        rst_n <= 1'b0;
        error_count = 0;
        pixels_taken = 0;
        burst_left = 0;
        hold_request = 1'b0;
        for (int i = 0; i < MAX_W; i++)
        begin
            line_cur[i] = '0;
            line_prev[i] = '0;
        end
        left_px = '0;
        col_pos = '0;
        row_pos = '0;
        cfg_width = 11'(RESET_WIDTH);
        cfg_height = 11'(RESET_HEIGHT);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_resize_mid_row();
        test_height_cut_mid_frame();
        test_extreme_sizes();
        test_backpressure();
        test_random_frames();

        wait_idle();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
